@@ hdl/per_sender_replay_table_unit_macros.svh @@
// Assertion macros for the per-sender replay table.
// Included by the top level only; depends on nothing else.
`ifndef PER_SENDER_REPLAY_TABLE_UNIT_MACROS_SVH
`define PER_SENDER_REPLAY_TABLE_UNIT_MACROS_SVH
// Assert an implication on the rising clock, ignored while in reset.
`define PSRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert an implication on the next clock cycle, ignored while in reset.
`define PSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/psrt_pkg.sv @@
// Shared types and constants of the per-sender replay table.
// Used by the front queue, the table engine and the top level.
package psrt_pkg;
    localparam int unsigned ADDR_W = 48;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned IN_TDATA_W = 88;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef enum logic {
        MODE_CHECK  = 1'b0,
        MODE_RECORD = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [ADDR_W-1:0]  addr;
        logic [CNT_W-1:0]   cnt;
    } t_req;

    typedef struct packed {
        logic is_fresh;
        logic known_sender;
    } t_rsp;
endpackage

@@ hdl/per_sender_replay_table_unit.sv @@
// Per-sender anti-replay table: top level joining front queue and engine.
// Depends on psrt_pkg, psrt_front, psrt_engine and the assertion macros.
//
// Usage:
//   Input stream (s_axis): tdata = {msg_counter, sender_addr}, tuser = mode
//   (0 check only, 1 check and record). One request gives one result.
//   Output stream (m_axis): tdata bit 0 is_fresh, bit 1 known_sender.
//   Freshness is judged from the table as it stood before this request.
//   Path: an accepted request is held in the queue register, then the
//   table engine registers its result.
//   Throughput: one request per cycle unless a stalled result holds the flow;
//   the engine matches all ENTRIES slots in parallel and updates the chosen slot at the same edge.
//   Stall: when m_axis_tready is low the result holds, the engine stops and
//   the two-entry queue fills, after which s_axis_tready drops.
//   Reset: synchronous, active low; clears all valid bits, the stamp clock
//   and the queue. No clearing pass is needed.
`include "per_sender_replay_table_unit_macros.svh"
module per_sender_replay_table_unit #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // [47:0] sender_addr, [79:48] msg_counter
    input  logic        s_axis_tuser,  // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [0] is_fresh, [1] known_sender
);
    psrt_pkg::t_req w_in_req, w_q_req;
    psrt_pkg::t_rsp w_rsp;
    logic           w_q_valid, w_q_ready;

    assign w_in_req.mode = psrt_pkg::t_mode'(s_axis_tuser);
    assign w_in_req.addr = s_axis_tdata[47:0];
    assign w_in_req.cnt  = s_axis_tdata[79:48];

    psrt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (w_in_req),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_req   (w_q_req)
    );

    psrt_engine #(.ENTRIES(ENTRIES)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_req   (w_q_req),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rsp   (w_rsp)
    );

    assign m_axis_tdata = {6'b0, w_rsp.known_sender, w_rsp.is_fresh};

    `PSRT_ASSERT_IMP(a_unknown_is_fresh, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[1], m_axis_tdata[0], "unknown sender reported stale")
    `PSRT_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n, w_q_valid && w_q_ready, m_axis_tvalid, "engine took request without result")
    `PSRT_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid, "stalled result changed")
endmodule

@@ hdl/psrt_front.sv @@
// Front part: accepts requests and holds them in a two-entry queue.
// Depends on psrt_pkg.
module psrt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  psrt_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output psrt_pkg::t_req o_req
);
    psrt_pkg::t_req r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

@@ hdl/psrt_engine.sv @@
// Back part: table lookup, update and allocation, with an output register.
// Depends on psrt_pkg.
module psrt_engine #(
    parameter int unsigned ENTRIES = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  psrt_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output psrt_pkg::t_rsp o_rsp
);
    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned LRU_N = 1 << IDX_W;

    logic [ENTRIES-1:0]             r_valid;
    logic [psrt_pkg::ADDR_W-1:0]    r_sender [ENTRIES];
    logic [psrt_pkg::CNT_W-1:0]     r_last   [ENTRIES];
    logic [psrt_pkg::STAMP_W-1:0]   r_stamp  [ENTRIES];
    logic [psrt_pkg::STAMP_W-1:0]   r_clock;
    logic                           r_ovalid;
    psrt_pkg::t_rsp                 r_rsp;

    logic [ENTRIES-1:0]             w_match;
    logic                           w_hit;
    logic [IDX_W-1:0]               w_hit_idx;
    logic                           w_has_free;
    logic [IDX_W-1:0]               w_free_idx;
    logic [IDX_W-1:0]               w_lru_idx;
    logic [IDX_W-1:0]               w_lru_cand  [LRU_N];
    logic [psrt_pkg::STAMP_W-1:0]   w_lru_stamp [LRU_N];
    logic [IDX_W-1:0]               w_slot;
    logic                           w_fresh;
    logic                           w_take;
    logic [psrt_pkg::STAMP_W-1:0]   n_clock;

    // Match all entries in parallel; lowest index wins.
    always_comb begin
        w_hit = 1'b0;
        w_hit_idx = '0;
        w_has_free = 1'b0;
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            w_match[i] = r_valid[i] && (r_sender[i] == i_req.addr);
            if (w_match[i]) begin
                w_hit = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_has_free = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    // Least recently used slot: a compare tree over the stamps, the lower
    // side of each pair wins ties so the lowest index comes out on top.
    always_comb begin
        for (int i = 0; i < LRU_N; i++) begin
            w_lru_cand[i]  = IDX_W'(i);
            w_lru_stamp[i] = '1;
            if (i < ENTRIES) w_lru_stamp[i] = r_stamp[i];
        end
        for (int s = 1; s < LRU_N; s = s * 2) begin
            for (int i = 0; i + s < LRU_N; i = i + 2 * s) begin
                if (w_lru_stamp[i + s] < w_lru_stamp[i]) begin
                    w_lru_stamp[i] = w_lru_stamp[i + s];
                    w_lru_cand[i]  = w_lru_cand[i + s];
                end
            end
        end
        w_lru_idx = w_lru_cand[0];
    end

    assign w_fresh = !w_hit || (i_req.cnt > r_last[w_hit_idx]);
    assign w_slot  = w_hit ? w_hit_idx : (w_has_free ? w_free_idx : w_lru_idx);
    assign o_ready = !r_ovalid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign n_clock = r_clock + 1'b1;
    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rsp.is_fresh     <= w_fresh;
            r_rsp.known_sender <= w_hit;
            if (i_req.mode == psrt_pkg::MODE_RECORD) begin
                r_stamp[w_slot] <= n_clock;
                if (!w_hit) begin
                    r_sender[w_slot] <= i_req.addr;
                    r_last[w_slot]   <= i_req.cnt;
                end else if (w_fresh) begin
                    r_last[w_slot] <= i_req.cnt;
                end
            end
        end
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_clock  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_take) begin
                r_ovalid <= 1'b1;
                if (i_req.mode == psrt_pkg::MODE_RECORD) begin
                    r_clock <= n_clock;
                    r_valid[w_slot] <= 1'b1;
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule
